// ----- hw/rtl/gb5_pkg.sv -----
// Shared types, constants and the 5-tap binomial kernel of the RGB blur.
`default_nettype none

package gb5_pkg;

   localparam int PIX_W      = 24;
   localparam int LANES      = 4;
   localparam int FIFO_DEPTH = 16;

   localparam logic [10:0] RST_WIDTH  = 11'd640;
   localparam logic [10:0] RST_HEIGHT = 11'd480;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   typedef enum logic [0:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic       opcode;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic       frame_last;
   } rsp_type;

   // Taps 1,4,6,4,1 per channel, rounded as (s + 8) >> 4.
   function automatic logic [PIX_W-1:0] blur5(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b,
                                              input logic [PIX_W-1:0] c,
                                              input logic [PIX_W-1:0] d,
                                              input logic [PIX_W-1:0] e);
      logic [PIX_W-1:0] r;
      logic [11:0]      s;
      r = '0;
      for (int k = 0; k < 3; k++) begin
         s = 12'(a[k*8 +: 8]) + {2'b0, b[k*8 +: 8], 2'b0}
           + {2'b0, c[k*8 +: 8], 2'b0} + {3'b0, c[k*8 +: 8], 1'b0}
           + {2'b0, d[k*8 +: 8], 2'b0} + 12'(e[k*8 +: 8]) + 12'd8;
         r[k*8 +: 8] = s[11:4];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/gaussian_blur_5tap_rgb.sv -----
// Top level of the streaming 5x5 separable Gaussian blur for RGB pixels.
//
// Usage: pixels enter in raster order on req_* (opcode pixel). Each row is
// blurred horizontally (taps 1,4,6,4,1 / 16, edges replicated) and written to
// a four-row line store, then blurred down the column. Blurred pixels leave
// in raster order on rsp_*; frame_last marks the final pixel of the frame.
// After the last input pixel, drain transfers (opcode drain) pull out the
// last two rows, one pixel per transfer.
// csr_* writes frame_width (index 0) or frame_height (index 1); a write
// restarts the frame. csr_ready is low while column jobs are in flight.
// Throughput: one transfer per cycle while req_ready is high; the last pixel
// of each row holds req_ready low while its extra column jobs issue (two from
// width 3, one at width 2, none at width 1), as the single line-store port serves one
// column read-modify-write per cycle.
// Result path: a result passes the issue register, the line-store read and
// the result FIFO before it is presented, or later when a transfer releases it.
// Reset: size 640 x 480, positions cleared; line store contents undefined.
// Receiver stall: results queue in a 16-entry result FIFO; req_ready drops
// when the FIFO could not take the values of another transfer.
`default_nettype none

module gaussian_blur_5tap_rgb #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire gb5_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output gb5_pkg::rsp_type      rsp_payload,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [0:0]       csr_index,
   input  wire logic [10:0]      csr_wdata
);

   localparam int CW    = (MAX_WIDTH > 4) ? $clog2(MAX_WIDTH) : 2;
   localparam int RW    = (MAX_HEIGHT > 4) ? $clog2(MAX_HEIGHT) : 2;
   localparam int AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int PW    = gb5_pkg::PIX_W;
   localparam int LANES = gb5_pkg::LANES;
   localparam int FD    = gb5_pkg::FIFO_DEPTH;
   localparam int FAW   = $clog2(FD);
   localparam int OW    = $clog2(FD + 1);

   // One column operation on the line store.
   typedef struct packed {
      logic            wr;       // write hv into lane wlane
      logic            calc;     // produce a vertical result
      logic            last;     // result is the frame's final pixel
      logic            use_hv;   // bottom tap is hv, not the store
      logic [CW-1:0]   col;
      logic [1:0]      wlane;
      logic [4:0][1:0] sel;      // store lane per vertical tap
      logic [PW-1:0]   hv;
   } job_type;

   function automatic logic [CW-1:0] last_col(input logic [10:0] v);
      int t;
      t = int'(v);
      if (t < 1) t = 1;
      if (t > MAX_WIDTH) t = MAX_WIDTH;
      return CW'(t - 1);
   endfunction

   function automatic logic [RW-1:0] last_row(input logic [10:0] v);
      int t;
      t = int'(v);
      if (t < 1) t = 1;
      if (t > MAX_HEIGHT) t = MAX_HEIGHT;
      return RW'(t - 1);
   endfunction

   function automatic job_type mk_prod(input logic [CW-1:0] col, input logic [PW-1:0] hv,
                                       input logic [RW-1:0] row);
      job_type        j;
      logic [RW-1:0]  oy;
      logic [RW-1:0]  r0;
      logic [RW-1:0]  r1;
      logic [RW-1:0]  r3;
      oy = row - RW'(2);
      r0 = (oy >= RW'(2)) ? oy - RW'(2) : '0;
      r1 = (oy >= RW'(1)) ? oy - RW'(1) : '0;
      r3 = row - RW'(1);
      j        = '0;
      j.wr     = 1'b1;
      j.calc   = (row >= RW'(2));
      j.use_hv = 1'b1;
      j.col    = col;
      j.wlane  = row[1:0];
      j.sel[0] = r0[1:0];
      j.sel[1] = r1[1:0];
      j.sel[2] = oy[1:0];
      j.sel[3] = r3[1:0];
      j.hv     = hv;
      return j;
   endfunction

   // Frame geometry and positions
   logic [CW-1:0] wlast_ff, wlast_in;
   logic [RW-1:0] hlast_ff, hlast_in;
   logic [CW-1:0] in_col_ff, in_col_in;
   logic [RW-1:0] in_row_ff, in_row_in;
   logic [CW-1:0] out_col_ff, out_col_in;
   logic [RW-1:0] out_row_ff, out_row_in;
   logic [2:0]    pend_ff, pend_in;
   logic          done_ff, done_in;
   logic [PW-1:0] win_ff [4];
   logic [PW-1:0] win_in [4];

   // Job issue and read stages
   logic          issue_v_ff, issue_v_in;
   job_type       issue_ff, issue_in;
   job_type       tail_ff [2];
   job_type       tail_in [2];
   logic [1:0]    tail_cnt_ff, tail_cnt_in;
   logic          rd_v_ff;
   job_type       rd_ff;

   // Result FIFO and release accounting
   logic [PW:0]   fifo_ff [FD];
   logic [FAW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [OW-1:0] cnt_ff, cnt_in;
   logic [OW-1:0] owed_ff, owed_in;
   logic [OW-1:0] tok_ff, tok_in;

   logic          req_fire, rsp_fire, csr_fire;
   logic          is_drain, emit, row_end;
   logic [1:0]    vals;
   logic [2:0]    push;
   logic [PW-1:0] pix, s0, s1, s2, s3, hv_a, hv_b, hv_c;
   job_type       drain_job;
   logic [RW:0]   ye, hle, rp1, rp2;
   logic [RW-1:0] rm1, rm2;

   logic [LANES-1:0][PW-1:0] ram_rdata;
   logic [LANES*PW-1:0]      ram_rd_raw;
   logic [LANES-1:0]         ram_we;
   logic [PW-1:0]            taps [5];
   logic [PW-1:0]            vert;
   logic                     fifo_push;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;
   assign csr_fire = csr_valid && csr_ready;

   assign req_ready = (tail_cnt_ff == 2'd0) && (owed_ff <= OW'(FD - 3));
   assign csr_ready = !issue_v_ff && !rd_v_ff && (tail_cnt_ff == 2'd0);

   // Horizontal pass; the row's first pixel fills the window
   assign pix = {req_payload.red, req_payload.green, req_payload.blue};
   assign s0  = (in_col_ff == '0) ? pix : win_ff[0];
   assign s1  = (in_col_ff == '0) ? pix : win_ff[1];
   assign s2  = (in_col_ff == '0) ? pix : win_ff[2];
   assign s3  = (in_col_ff == '0) ? pix : win_ff[3];
   assign hv_a = gb5_pkg::blur5(s0, s1, s2, s3, pix);
   assign hv_b = gb5_pkg::blur5(s1, s2, s3, pix, pix);
   assign hv_c = gb5_pkg::blur5(s2, s3, pix, pix, pix);
   assign row_end  = (in_col_ff == wlast_ff);
   assign is_drain = (req_payload.opcode == gb5_pkg::OP_DRAIN) || done_ff;

   // Bottom rows read from the store with edge rows clamped
   always_comb begin
      ye  = {1'b0, out_row_ff};
      hle = {1'b0, hlast_ff};
      rm2 = (out_row_ff >= RW'(2)) ? out_row_ff - RW'(2) : '0;
      rm1 = (out_row_ff >= RW'(1)) ? out_row_ff - RW'(1) : '0;
      rp1 = ((ye + (RW+1)'(1)) > hle) ? hle : ye + (RW+1)'(1);
      rp2 = ((ye + (RW+1)'(2)) > hle) ? hle : ye + (RW+1)'(2);
      drain_job        = '0;
      drain_job.calc   = 1'b1;
      drain_job.last   = (out_row_ff == hlast_ff) && (out_col_ff == wlast_ff);
      drain_job.col    = out_col_ff;
      drain_job.sel[0] = rm2[1:0];
      drain_job.sel[1] = rm1[1:0];
      drain_job.sel[2] = out_row_ff[1:0];
      drain_job.sel[3] = rp1[1:0];
      drain_job.sel[4] = rp2[1:0];
   end

   always_comb begin
      wlast_in    = wlast_ff;
      hlast_in    = hlast_ff;
      in_col_in   = in_col_ff;
      in_row_in   = in_row_ff;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      done_in     = done_ff;
      win_in      = win_ff;
      issue_v_in  = 1'b0;
      issue_in    = issue_ff;
      tail_in     = tail_ff;
      tail_cnt_in = tail_cnt_ff;
      vals        = 2'd0;
      push        = 3'd0;
      emit        = 1'b0;
      pend_in     = pend_ff;

      if (tail_cnt_ff != 2'd0) begin
         issue_v_in  = 1'b1;
         issue_in    = tail_ff[0];
         tail_in[0]  = tail_ff[1];
         tail_cnt_in = tail_cnt_ff - 2'd1;
      end

      if (req_fire) begin
         if (is_drain) begin
            if (pend_ff != 3'd0) begin
               emit    = 1'b1;
               pend_in = pend_ff - 3'd1;
            end else if (done_ff) begin
               emit       = 1'b1;
               issue_v_in = 1'b1;
               issue_in   = drain_job;
               vals       = 2'd1;
            end
         end else begin
            priority if (row_end && in_col_ff >= CW'(2)) begin
               issue_v_in  = 1'b1;
               issue_in    = mk_prod(in_col_ff - CW'(2), hv_a, in_row_ff);
               tail_in[0]  = mk_prod(in_col_ff - CW'(1), hv_b, in_row_ff);
               tail_in[1]  = mk_prod(in_col_ff, hv_c, in_row_ff);
               tail_cnt_in = 2'd2;
               vals        = 2'd3;
            end else if (row_end && in_col_ff == CW'(1)) begin
               issue_v_in  = 1'b1;
               issue_in    = mk_prod(in_col_ff - CW'(1), hv_b, in_row_ff);
               tail_in[0]  = mk_prod(in_col_ff, hv_c, in_row_ff);
               tail_cnt_in = 2'd1;
               vals        = 2'd2;
            end else if (row_end) begin
               issue_v_in = 1'b1;
               issue_in   = mk_prod(in_col_ff, hv_c, in_row_ff);
               vals       = 2'd1;
            end else if (in_col_ff >= CW'(2)) begin
               issue_v_in = 1'b1;
               issue_in   = mk_prod(in_col_ff - CW'(2), hv_a, in_row_ff);
               vals       = 2'd1;
            end else begin
               vals = 2'd0;
            end
            // top two rows only fill the store
            if (in_row_ff < RW'(2)) vals = 2'd0;
            push = {1'b0, vals};

            win_in[0] = s1;
            win_in[1] = s2;
            win_in[2] = s3;
            win_in[3] = pix;

            if (row_end) begin
               in_col_in = '0;
               if (in_row_ff == hlast_ff) begin
                  in_row_in = '0;
                  done_in   = 1'b1;
               end else begin
                  in_row_in = in_row_ff + RW'(1);
               end
            end else begin
               in_col_in = in_col_ff + CW'(1);
            end

            if ((pend_ff + push) != 3'd0) begin
               emit    = 1'b1;
               pend_in = pend_ff + push - 3'd1;
            end else begin
               pend_in = pend_ff + push;
            end
         end

         if (emit) begin
            if (out_row_ff == hlast_ff && out_col_ff == wlast_ff) begin
               // frame complete: next frame starts from the top
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
               pend_in    = 3'd0;
               done_in    = 1'b0;
            end else if (out_col_ff == wlast_ff) begin
               out_col_in = '0;
               out_row_in = out_row_ff + RW'(1);
            end else begin
               out_col_in = out_col_ff + CW'(1);
            end
         end
      end

      owed_in = owed_ff + OW'(vals) - OW'(rsp_fire);
      tok_in  = tok_ff + OW'(emit) - OW'(rsp_fire);

      if (csr_fire) begin
         unique case (gb5_pkg::csr_index_type'(csr_index))
            gb5_pkg::CSR_FRAME_WIDTH:  wlast_in = last_col(csr_wdata);
            gb5_pkg::CSR_FRAME_HEIGHT: hlast_in = last_row(csr_wdata);
         endcase
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
         pend_in    = 3'd0;
         done_in    = 1'b0;
         owed_in    = '0;
         tok_in     = '0;
      end
   end

   // Line store: lane = row & 3, address = column
   assign ram_we = (issue_v_ff && issue_ff.wr) ? (LANES'(1) << issue_ff.wlane) : '0;

   gb5_ram #(
      .WIDTH (LANES * PW),
      .DEPTH (MAX_WIDTH),
      .LANES (LANES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (issue_ff.col[AW-1:0]),
      .wr_data ({LANES{issue_ff.hv}}),
      .rd_data (ram_rd_raw)
   );

   assign ram_rdata = ram_rd_raw;

   // Vertical pass on the read data
   always_comb begin
      for (int k = 0; k < 5; k++) begin
         taps[k] = ram_rdata[rd_ff.sel[k]];
      end
      if (rd_ff.use_hv) taps[4] = rd_ff.hv;
      vert = gb5_pkg::blur5(taps[0], taps[1], taps[2], taps[3], taps[4]);
   end

   assign fifo_push = rd_v_ff && rd_ff.calc;

   always_comb begin
      wp_in  = fifo_push ? wp_ff + FAW'(1) : wp_ff;
      rp_in  = rsp_fire ? rp_ff + FAW'(1) : rp_ff;
      cnt_in = cnt_ff + OW'(fifo_push) - OW'(rsp_fire);
      if (csr_fire) begin
         wp_in  = '0;
         rp_in  = '0;
         cnt_in = '0;
      end
   end

   assign rsp_valid              = (tok_ff != '0) && (cnt_ff != '0);
   assign rsp_payload.out_red    = fifo_ff[rp_ff][PW-1:16];
   assign rsp_payload.out_green  = fifo_ff[rp_ff][15:8];
   assign rsp_payload.out_blue   = fifo_ff[rp_ff][7:0];
   assign rsp_payload.frame_last = fifo_ff[rp_ff][PW];

   always_ff @(posedge clock) begin
      if (reset) begin
         wlast_ff    <= last_col(gb5_pkg::RST_WIDTH);
         hlast_ff    <= last_row(gb5_pkg::RST_HEIGHT);
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         pend_ff     <= '0;
         done_ff     <= 1'b0;
         issue_v_ff  <= 1'b0;
         tail_cnt_ff <= '0;
         rd_v_ff     <= 1'b0;
         wp_ff       <= '0;
         rp_ff       <= '0;
         cnt_ff      <= '0;
         owed_ff     <= '0;
         tok_ff      <= '0;
      end else begin
         wlast_ff    <= wlast_in;
         hlast_ff    <= hlast_in;
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         pend_ff     <= pend_in;
         done_ff     <= done_in;
         issue_v_ff  <= issue_v_in;
         tail_cnt_ff <= tail_cnt_in;
         rd_v_ff     <= issue_v_ff;
         wp_ff       <= wp_in;
         rp_ff       <= rp_in;
         cnt_ff      <= cnt_in;
         owed_ff     <= owed_in;
         tok_ff      <= tok_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      win_ff   <= win_in;
      issue_ff <= issue_in;
      tail_ff  <= tail_in;
      rd_ff    <= issue_ff;
      if (fifo_push) begin
         fifo_ff[wp_ff] <= {rd_ff.last, vert};
      end
   end

   // Released results never outrun values owed
   a_tok_owed: assert property (@(posedge clock) disable iff (reset) tok_ff <= owed_ff)
      else $error("released results exceed owed values");

   a_fifo_owed: assert property (@(posedge clock) disable iff (reset) cnt_ff <= owed_ff)
      else $error("result FIFO holds more than owed");

   a_pend: assert property (@(posedge clock) disable iff (reset) pend_ff <= 3'd3)
      else $error("pending queue deeper than expected");

   a_tail_issue: assert property (@(posedge clock) disable iff (reset)
      (tail_cnt_ff != 2'd0) |-> issue_v_ff)
      else $error("tail jobs waiting without an issue in progress");

   a_fifo_room: assert property (@(posedge clock) disable iff (reset)
      fifo_push |-> (cnt_ff < OW'(FD)))
      else $error("result FIFO overflow");

endmodule

`default_nettype wire

// ----- hw/rtl/gb5_ram.sv -----
// Generic single-port RAM with per-lane write enables and registered read (read-first).
`default_nettype none

module gb5_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 1024,
   parameter int LANES = 4,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int LW   = WIDTH / LANES
) (
   input  wire logic             clock,
   input  wire logic [LANES-1:0] wr_en,
   input  wire logic [AW-1:0]    addr,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      for (int l = 0; l < LANES; l++) begin
         if (wr_en[l]) begin
            mem[addr][l*LW +: LW] <= wr_data[l*LW +: LW];
         end
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking testbench for the streaming 5x5 RGB Gaussian blur.
`timescale 1ns / 100ps
`default_nettype none

module tb;

   localparam int MAXW      = 1024;
   localparam int MAXH      = 1024;
   localparam int CYC_LIMIT = 1000000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   gb5_pkg::req_type       req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   gb5_pkg::rsp_type       rsp_payload;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   gb5_pkg::csr_index_type csr_index = gb5_pkg::CSR_FRAME_WIDTH;
   logic [10:0]            csr_wdata = '0;

   gaussian_blur_5tap_rgb dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Shadow of the blur: size registers, line store, row window,
   // positions and the short queue of finished pixels.
   // ---------------------------------------------------------------
   logic [10:0] shd_width, shd_height;
   logic [23:0] line_mem [0:4*MAXW-1];
   logic [23:0] row_win [0:3];
   logic [23:0] ready_px [$];
   int          in_col, in_row, out_col, out_row;
   bit          frame_in_done;

   gb5_pkg::rsp_type blurred_q [$];   // blurred pixels still owed by the block
   gb5_pkg::req_type pending_q [$];   // items waiting for the driver

   int          mismatches = 0;
   int          cycles = 0;
   int          n_items = 0;
   int          n_results = 0;
   int          n_frames_last = 0;
   bit          quiet = 1'b0;

   function automatic int eff_width();
      return (shd_width == 0) ? 1 : ((shd_width > MAXW) ? MAXW : int'(shd_width));
   endfunction

   function automatic int eff_height();
      return (shd_height == 0) ? 1 : ((shd_height > MAXH) ? MAXH : int'(shd_height));
   endfunction

   function automatic logic [23:0] tap5(input logic [23:0] a, b, c, d, e);
      logic [23:0] r;
      int          s;
      for (int k = 0; k < 3; k++) begin
         s = a[k*8 +: 8] + 4*b[k*8 +: 8] + 6*c[k*8 +: 8] + 4*d[k*8 +: 8] + e[k*8 +: 8];
         r[k*8 +: 8] = 8'((s + 8) >> 4);
      end
      return r;
   endfunction

   function automatic logic [23:0] line_rd(input int row, input int col);
      return line_mem[(row & 3) * MAXW + (col % MAXW)];
   endfunction

   function automatic int clamp_row(input int r, input int h);
      return (r < 0) ? 0 : ((r >= h) ? h - 1 : r);
   endfunction

   task automatic frame_restart();
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      ready_px.delete();
      frame_in_done = 1'b0;
   endtask

   task automatic owe_pixel(input logic [23:0] v);
      gb5_pkg::rsp_type o;
      bit               last;
      last = (out_row >= eff_height() - 1) && (out_col >= eff_width() - 1);
      o.out_red = v[23:16]; o.out_green = v[15:8]; o.out_blue = v[7:0];
      o.frame_last = last;
      blurred_q.push_back(o);
      if (last) begin
         frame_restart();
      end else begin
         out_col++;
         if (out_col >= eff_width()) begin
            out_col = 0;
            out_row++;
         end
      end
   endtask

   // Horizontal result for one column: finishes that column's pixel two rows up.
   task automatic put_column(input int col, input logic [23:0] hv);
      int oy;
      if (in_row >= 2) begin
         oy = in_row - 2;
         if (ready_px.size() < 4)
            ready_px.push_back(tap5(line_rd((oy >= 2) ? oy - 2 : 0, col),
                                    line_rd((oy >= 1) ? oy - 1 : 0, col),
                                    line_rd(oy, col), line_rd(oy + 1, col), hv));
      end
      line_mem[(in_row & 3) * MAXW + (col % MAXW)] = hv;
   endtask

   task automatic drain_one();
      int h;
      h = eff_height();
      if (ready_px.size() > 0) begin
         owe_pixel(ready_px.pop_front());
      end else if (frame_in_done) begin
         owe_pixel(tap5(line_rd(clamp_row(out_row - 2, h), out_col),
                        line_rd(clamp_row(out_row - 1, h), out_col),
                        line_rd(clamp_row(out_row, h), out_col),
                        line_rd(clamp_row(out_row + 1, h), out_col),
                        line_rd(clamp_row(out_row + 2, h), out_col)));
      end
   endtask

   task automatic blur_accept(input gb5_pkg::req_type q);
      logic [23:0] pix;
      logic [23:0] s [0:6];
      int          w, x;
      w = eff_width();
      if (q.opcode == gb5_pkg::OP_DRAIN || frame_in_done) begin
         drain_one();
      end else begin
         pix = {q.red, q.green, q.blue};
         x = in_col;
         if (x == 0)
            for (int i = 0; i < 4; i++) row_win[i] = pix;
         for (int i = 0; i < 4; i++) s[i] = row_win[i];
         s[4] = pix; s[5] = pix; s[6] = pix;
         if (x >= 2) put_column(x - 2, tap5(s[0], s[1], s[2], s[3], s[4]));
         if (x >= w - 1) begin
            if (x >= 1) put_column(x - 1, tap5(s[1], s[2], s[3], s[4], s[5]));
            put_column(x, tap5(s[2], s[3], s[4], s[5], s[6]));
         end
         row_win[0] = row_win[1]; row_win[1] = row_win[2];
         row_win[2] = row_win[3]; row_win[3] = pix;
         in_col++;
         if (in_col >= w) begin
            in_col = 0;
            in_row++;
            if (in_row >= eff_height()) begin
               in_row = 0;
               frame_in_done = 1'b1;
            end
         end
         if (ready_px.size() > 0) owe_pixel(ready_px.pop_front());
      end
   endtask

   // ---------------------------------------------------------------
   // Monitor: at the rising edge, predict from the accepted transfer,
   // then check any result transfer against the oldest owed pixel.
   // ---------------------------------------------------------------
   bit req_taken = 1'b0;

   always @(posedge clock) begin
      gb5_pkg::rsp_type e;
      cycles <= cycles + 1;
      if (cycles > CYC_LIMIT) begin
         $display("timeout after %0d cycles, %0d results owed", cycles, blurred_q.size());
         $display("tb: errors");
         $finish;
      end
      req_taken = 1'b0;
      if (!reset && req_valid && req_ready) begin
         blur_accept(req_payload);
         n_items++;
         req_taken = 1'b1;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         n_results++;
         if (rsp_payload.frame_last) n_frames_last++;
         if (blurred_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result transfer %h", rsp_payload);
         end else begin
            e = blurred_q.pop_front();
            if (e.out_red !== rsp_payload.out_red || e.out_green !== rsp_payload.out_green
                || e.out_blue !== rsp_payload.out_blue
                || e.frame_last !== rsp_payload.frame_last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d: expected r%h g%h b%h last%b, got r%h g%h b%h last%b",
                           n_results, e.out_red, e.out_green, e.out_blue, e.frame_last,
                           rsp_payload.out_red, rsp_payload.out_green,
                           rsp_payload.out_blue, rsp_payload.frame_last);
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Driver and receiver, both changing at the falling edge.
   // Random idle bursts, none once quiet is set.
   // ---------------------------------------------------------------
   int req_gap = 0;
   int rsp_gap = 0;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            req_gap = $urandom_range(0, 8);
            req_valid <= 1'b0;
         end else if (pending_q.size() > 0) begin
            req_payload <= pending_q.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
         rsp_gap = $urandom_range(0, 8);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   function automatic gb5_pkg::req_type make_pixel();
      gb5_pkg::req_type q;
      q.opcode = gb5_pkg::OP_PIXEL;
      case ($urandom_range(0, 9))
         0:       {q.red, q.green, q.blue} = 24'h000000;
         1:       {q.red, q.green, q.blue} = 24'hffffff;
         default: {q.red, q.green, q.blue} = 24'($urandom());
      endcase
      return q;
   endfunction

   function automatic gb5_pkg::req_type make_rgb(input logic [23:0] v);
      gb5_pkg::req_type q;
      q.opcode = gb5_pkg::OP_PIXEL;
      {q.red, q.green, q.blue} = v;
      return q;
   endfunction

   function automatic gb5_pkg::req_type make_drain();
      gb5_pkg::req_type q;
      q = gb5_pkg::req_type'(25'($urandom()));
      q.opcode = gb5_pkg::OP_DRAIN;
      return q;
   endfunction

   // Wait until every owed pixel has arrived and the block has gone quiet.
   task automatic settle();
      while (pending_q.size() > 0 || req_valid || blurred_q.size() > 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic csr_write(input gb5_pkg::csr_index_type idx, input logic [10:0] val);
      @(negedge clock);
      csr_index <= idx;
      csr_wdata <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      if (idx == gb5_pkg::CSR_FRAME_WIDTH) shd_width = val;
      else shd_height = val;
      frame_restart();
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_size(input logic [10:0] w, input logic [10:0] h);
      settle();
      if ($urandom_range(0, 1)) begin
         csr_write(gb5_pkg::CSR_FRAME_WIDTH, w);
         csr_write(gb5_pkg::CSR_FRAME_HEIGHT, h);
      end else begin
         csr_write(gb5_pkg::CSR_FRAME_HEIGHT, h);
         csr_write(gb5_pkg::CSR_FRAME_WIDTH, w);
      end
   endtask

   // One whole frame: pixels with the odd stray drain, then enough drains
   // to flush the last two rows; a few stray pixels in the flush act as drains.
   task automatic queue_frame(input bit noisy);
      int np;
      np = eff_width() * eff_height();
      for (int i = 0; i < np; i++) begin
         if (noisy && $urandom_range(0, 11) == 0) pending_q.push_back(make_drain());
         pending_q.push_back(make_pixel());
      end
      for (int i = 0; i < 2 * eff_width() + 4; i++)
         if (noisy && $urandom_range(0, 15) == 0) pending_q.push_back(make_pixel());
         else pending_q.push_back(make_drain());
   endtask

   initial begin
      int target;
      shd_width  = gb5_pkg::RST_WIDTH;
      shd_height = gb5_pkg::RST_HEIGHT;
      for (int i = 0; i < 4*MAXW; i++) line_mem[i] = '0;
      for (int i = 0; i < 4; i++) row_win[i] = '0;
      frame_restart();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset size: part of one row, then a drain, which owes nothing.
      for (int i = 0; i < 8; i++) pending_q.push_back(make_pixel());
      pending_q.push_back(make_drain());

      // Directed: 1x1 black and white, out-of-range sizes, small frames.
      set_size(11'd1, 11'd1);
      pending_q.push_back(make_rgb(24'h000000));
      pending_q.push_back(make_drain());
      pending_q.push_back(make_rgb(24'hffffff));
      pending_q.push_back(make_drain());
      set_size(11'd0, 11'd0);
      queue_frame(1'b0);
      set_size(11'd3, 11'd2);
      pending_q.push_back(make_drain());
      queue_frame(1'b0);
      set_size(11'd5, 11'd4);
      for (int i = 0; i < 7; i++) pending_q.push_back(make_pixel());

      // Size fields at their largest codes, cut short by the next write.
      set_size(11'd2047, 11'd3);
      for (int i = 0; i < 40; i++) pending_q.push_back(make_pixel());
      set_size(11'd1, 11'd2047);
      for (int i = 0; i < 40; i++) pending_q.push_back(make_pixel());
      set_size(11'd1024, 11'd2047);
      for (int i = 0; i < 30; i++) pending_q.push_back(make_pixel());

      // Random frames, mostly small; one to three frames per size setting.
      target = n_items + 700;
      while (n_items + pending_q.size() < target) begin
         if ($urandom_range(0, 5) == 0)
            set_size(11'($urandom_range(1, 48)), 11'($urandom_range(1, 12)));
         else
            set_size(11'($urandom_range(1, 10)), 11'($urandom_range(1, 8)));
         repeat ($urandom_range(1, 3)) queue_frame(1'b1);
         if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 20)) pending_q.push_back(make_pixel());
      end

      // Closing stretch at full rate on both sides.
      settle();
      quiet = 1'b1;
      set_size(11'd7, 11'd5);
      queue_frame(1'b0);
      queue_frame(1'b1);

      settle();
      repeat (40) @(posedge clock);
      $display("covered %0d input transfers, %0d result transfers, %0d whole frames",
               n_items, n_results, n_frames_last);
      $display("sizes from 1x1 to 1024 wide and tall, with stray drains and pixels");
      if (mismatches == 0 && blurred_q.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("%0d mismatches, %0d results owed", mismatches, blurred_q.size());
         $display("tb: errors");
      end
      $finish;
   end

endmodule

`default_nettype wire
